// ----- rtl/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg: shared types and helpers for the spring leg stance derivative unit
// Item, result and register layouts, plus saturating fixed point helpers.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STIFFNESS,
		REG_REST_LENGTH,
		REG_INVERSE_MASS,
		REG_GRAVITY,
		REG_FOOT_X,
		REG_FOOT_Z,
		REG_TOUCHDOWN_HEIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] pos_z;
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] vel_z;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] dpos_x;
		logic signed [DATA_W-1:0] dpos_y;
		logic signed [DATA_W-1:0] dpos_z;
		logic signed [DATA_W-1:0] accel_x;
		logic signed [DATA_W-1:0] accel_y;
		logic signed [DATA_W-1:0] accel_z;
		logic signed [DATA_W-1:0] touchdown_margin;
	} result_t;

	typedef struct packed {
		logic [DATA_W-2:0]        stiffness;
		logic [DATA_W-2:0]        rest_length;
		logic [DATA_W-2:0]        inverse_mass;
		logic signed [DATA_W-1:0] gravity;
		logic signed [DATA_W-1:0] foot_x;
		logic signed [DATA_W-1:0] foot_z;
		logic signed [DATA_W-1:0] touchdown_height;
	} cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] vel_x;
		logic signed [DATA_W-1:0] vel_y;
		logic signed [DATA_W-1:0] vel_z;
		logic signed [DATA_W-1:0] margin;
	} pass_t;

	// neg and mag lanes: 0 = x, 1 = y, 2 = z
	typedef struct packed {
		pass_t             pass;
		logic [2:0]        neg;
		logic [DATA_W-1:0] mag_z;
		logic [DATA_W-1:0] mag_y;
		logic [DATA_W-1:0] mag_x;
	} front_rec_t;

	function automatic logic signed [DATA_W-1:0] sat_sub(
		input logic signed [DATA_W-1:0] a,
		input logic signed [DATA_W-1:0] b
	);
		logic signed [DATA_W:0] d;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		if (d[DATA_W] != d[DATA_W-1]) begin
			sat_sub = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			sat_sub = d[DATA_W-1:0];
		end
	endfunction

	function automatic logic [DATA_W-1:0] magnitude(input logic signed [DATA_W-1:0] v);
		magnitude = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
	endfunction

endpackage

// ----- rtl/sps_fifo.sv -----
// ----------------------------------------------------------------------------
// sps_fifo: small register queue
// Power of two depth, head shown on rdata while empty is low.
// ----------------------------------------------------------------------------
module sps_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == (AW+1)'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + (AW+1)'(1);
				end
				2'b01: begin
					cnt_q <= cnt_q - (AW+1)'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/sps_front.sv -----
// ----------------------------------------------------------------------------
// sps_front: item intake
// Leg vector relative to the stance foot, sign and magnitude per axis,
// touchdown margin; one register stage ahead of the work queue.
// ----------------------------------------------------------------------------
module sps_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  sps_pkg::item_t         item,
	input  sps_pkg::cfg_t          cfg,
	input  logic                   rec_full,
	output logic                   rec_valid,
	output sps_pkg::front_rec_t    rec
);
	import sps_pkg::*;

	logic                     valid_s1;
	front_rec_t               rec_s1;
	front_rec_t               rec_d;
	logic                     accept;
	logic signed [DATA_W-1:0] xr;
	logic signed [DATA_W-1:0] zr;

	assign full   = valid_s1 && rec_full;
	assign accept = push && !full;

	always_comb begin
		xr               = sat_sub(item.pos_x, cfg.foot_x);
		zr               = sat_sub(item.pos_z, cfg.foot_z);
		rec_d.pass.vel_x = item.vel_x;
		rec_d.pass.vel_y = item.vel_y;
		rec_d.pass.vel_z = item.vel_z;
		rec_d.pass.margin = sat_sub(cfg.touchdown_height, item.pos_y);
		rec_d.neg        = {zr[DATA_W-1], item.pos_y[DATA_W-1], xr[DATA_W-1]};
		rec_d.mag_x      = magnitude(xr);
		rec_d.mag_y      = magnitude(item.pos_y);
		rec_d.mag_z      = magnitude(zr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && rec_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1 <= rec_d;
		end
	end

	assign rec_valid = valid_s1;
	assign rec       = rec_s1;

endmodule

// ----- rtl/sps_sqrt.sv -----
// ----------------------------------------------------------------------------
// sps_sqrt: pipelined integer square root
// One root bit per stage, floor result, side data carried alongside.
// ----------------------------------------------------------------------------
module sps_sqrt #(
	parameter int W      = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ce,
	input  logic              in_valid,
	input  logic [2*W-1:0]    radicand,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [W-1:0]      root,
	output logic [SIDE_W-1:0] out_side
);
	localparam int RW = W + 2;

	logic              val_q  [W];
	logic [2*W-1:0]    rad_q  [W];
	logic [RW-1:0]     rem_q  [W];
	logic [W-1:0]      root_q [W];
	logic [SIDE_W-1:0] side_q [W];

	genvar i;
	generate
		for (i = 0; i < W; i++) begin : g_stage
			logic              v_in;
			logic [2*W-1:0]    rad_in;
			logic [RW-1:0]     rem_in;
			logic [W-1:0]      root_in;
			logic [SIDE_W-1:0] side_in;
			logic [RW-1:0]     rem_sh;
			logic [RW-1:0]     trial;
			logic              take;

			if (i == 0) begin : g_first
				assign v_in    = in_valid;
				assign rad_in  = radicand;
				assign rem_in  = '0;
				assign root_in = '0;
				assign side_in = in_side;
			end else begin : g_next
				assign v_in    = val_q[i-1];
				assign rad_in  = rad_q[i-1];
				assign rem_in  = rem_q[i-1];
				assign root_in = root_q[i-1];
				assign side_in = side_q[i-1];
			end

			assign rem_sh = {rem_in[RW-3:0], rad_in[2*W-1:2*W-2]};
			assign trial  = {root_in, 2'b01};
			assign take   = rem_sh >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					val_q[i] <= 1'b0;
				end else if (ce) begin
					val_q[i] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (ce) begin
					rad_q[i]  <= rad_in << 2;
					rem_q[i]  <= take ? (rem_sh - trial) : rem_sh;
					root_q[i] <= {root_in[W-2:0], take};
					side_q[i] <= side_in;
				end
			end
		end
	endgenerate

	assign out_valid = val_q[W-1];
	assign root      = root_q[W-1];
	assign out_side  = side_q[W-1];

endmodule

// ----- rtl/sps_div.sv -----
// ----------------------------------------------------------------------------
// sps_div: pipelined fractional divider, several lanes on one divisor
// Quotient of (num << (QW-1)) / den for num <= den, one bit per stage.
// ----------------------------------------------------------------------------
module sps_div #(
	parameter int LANES  = 3,
	parameter int DW     = 32,
	parameter int QW     = 17,
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  logic                        in_valid,
	input  logic [LANES-1:0][DW-1:0]    num,
	input  logic [DW-1:0]               den,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic [LANES-1:0][QW-1:0]    quot,
	output logic [SIDE_W-1:0]           out_side
);
	logic                     val_q  [QW];
	logic [DW-1:0]            den_q  [QW];
	logic [LANES-1:0][DW-1:0] rem_q  [QW];
	logic [LANES-1:0][QW-1:0] q_q    [QW];
	logic [SIDE_W-1:0]        side_q [QW];

	genvar j;
	generate
		for (j = 0; j < QW; j++) begin : g_stage
			logic                     v_in;
			logic [DW-1:0]            den_in;
			logic [LANES-1:0][DW-1:0] rem_in;
			logic [LANES-1:0][QW-1:0] q_in;
			logic [SIDE_W-1:0]        side_in;
			logic [LANES-1:0][DW:0]   rem_x;
			logic [LANES-1:0][DW-1:0] rem_n;
			logic [LANES-1:0][QW-1:0] q_n;

			if (j == 0) begin : g_first
				assign v_in    = in_valid;
				assign den_in  = den;
				assign rem_in  = num;
				assign q_in    = '0;
				assign side_in = in_side;
			end else begin : g_next
				assign v_in    = val_q[j-1];
				assign den_in  = den_q[j-1];
				assign rem_in  = rem_q[j-1];
				assign q_in    = q_q[j-1];
				assign side_in = side_q[j-1];
			end

			always_comb begin
				for (int k = 0; k < LANES; k++) begin
					rem_x[k] = (j == 0) ? {1'b0, rem_in[k]} : {rem_in[k], 1'b0};
					if (rem_x[k] >= {1'b0, den_in}) begin
						rem_n[k] = DW'(rem_x[k] - {1'b0, den_in});
						q_n[k]   = {q_in[k][QW-2:0], 1'b1};
					end else begin
						rem_n[k] = rem_x[k][DW-1:0];
						q_n[k]   = {q_in[k][QW-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					val_q[j] <= 1'b0;
				end else if (ce) begin
					val_q[j] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (ce) begin
					den_q[j]  <= den_in;
					rem_q[j]  <= rem_n;
					q_q[j]    <= q_n;
					side_q[j] <= side_in;
				end
			end
		end
	endgenerate

	assign out_valid = val_q[QW-1];
	assign quot      = q_q[QW-1];
	assign out_side  = side_q[QW-1];

endmodule

// ----- rtl/sps_back.sv -----
// ----------------------------------------------------------------------------
// sps_back: derivative datapath
// Squares, leg length root, direction divide, spring force, scaling,
// per axis component with gravity and saturation. Advances as one pipeline
// whenever the result queue has room.
// ----------------------------------------------------------------------------
module sps_back #(
	parameter int FRAC_BITS = sps_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sps_pkg::cfg_t       cfg,
	input  logic                in_valid,
	input  sps_pkg::front_rec_t in_rec,
	output logic                in_pop,
	input  logic                out_full,
	output logic                out_push,
	output sps_pkg::result_t    out_data
);
	import sps_pkg::*;

	localparam int W  = DATA_W;
	localparam int QW = FRAC_BITS + 1;
	localparam int PW = 2 * W - 2;
	localparam int AW = PW - FRAC_BITS;
	localparam int AL = AW / 2;
	localparam int AU = AW - AL;
	localparam int CW = ((AW + 1 > W) ? AW + 1 : W) + 1;

	typedef struct packed {
		pass_t      pass;
		logic [2:0] neg;
		logic [W-1:0] len;
	} div_side_t;

	typedef struct packed {
		pass_t                pass;
		logic [2:0]           neg;
		logic                 zero;
		logic [2:0][QW-1:0]   u;
	} carry_t;

	function automatic logic signed [W-1:0] sat_out(input logic signed [CW-1:0] v);
		if ((&v[CW-1:W-1]) || !(|v[CW-1:W-1])) begin
			sat_out = v[W-1:0];
		end else begin
			sat_out = v[CW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
	endfunction

	logic ce;
	assign ce     = !out_full;
	assign in_pop = ce && in_valid;

	// squares and sum
	logic           valid_s1, valid_s2;
	front_rec_t     rec_s1, rec_s2;
	logic [2*W-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic [2*W-1:0] sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_pop;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rec_s1 <= in_rec;
			sqx_s1 <= in_rec.mag_x * in_rec.mag_x;
			sqy_s1 <= in_rec.mag_y * in_rec.mag_y;
			sqz_s1 <= in_rec.mag_z * in_rec.mag_z;
			rec_s2 <= rec_s1;
			sum_s2 <= sqx_s1 + sqy_s1 + sqz_s1;
		end
	end

	// leg length
	logic                          sq_valid;
	logic [W-1:0]                  len;
	logic [$bits(front_rec_t)-1:0] sq_side;
	front_rec_t                    sq_rec;

	sps_sqrt #(
		.W      (W),
		.SIDE_W ($bits(front_rec_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (valid_s2),
		.radicand  (sum_s2),
		.in_side   (rec_s2),
		.out_valid (sq_valid),
		.root      (len),
		.out_side  (sq_side)
	);

	assign sq_rec = sq_side;

	// direction per axis
	logic [2:0][W-1:0]            dv_num;
	div_side_t                    dv_in_side;
	logic                         dv_valid;
	logic [2:0][QW-1:0]           dv_quot;
	logic [$bits(div_side_t)-1:0] dv_side_raw;
	div_side_t                    dv_side;

	assign dv_num          = {sq_rec.mag_z, sq_rec.mag_y, sq_rec.mag_x};
	assign dv_in_side.pass = sq_rec.pass;
	assign dv_in_side.neg  = sq_rec.neg;
	assign dv_in_side.len  = len;

	sps_div #(
		.LANES  (3),
		.DW     (W),
		.QW     (QW),
		.SIDE_W ($bits(div_side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (sq_valid),
		.num       (dv_num),
		.den       (len),
		.in_side   (dv_in_side),
		.out_valid (dv_valid),
		.quot      (dv_quot),
		.out_side  (dv_side_raw)
	);

	assign dv_side = dv_side_raw;

	// force and components
	logic                     valid_b1, valid_b2, valid_b3, valid_b4, valid_b5, valid_b6;
	carry_t                   carry_b1, carry_b2, carry_b3, carry_b4, carry_b5, carry_b6;
	logic [W-2:0]             diff_b1;
	logic [PW-1:0]            fprod_b2;
	logic [W-2:0]             f_b3;
	logic [PW-1:0]            aprod_b4;
	logic [2:0][AL+QW-1:0]    plo_b5;
	logic [2:0][AU+QW-1:0]    phi_b5;
	logic [2:0][AW-1:0]       c_b6;
	logic                     len_lt;
	logic [AW-1:0]            a_val;
	logic [2:0][AW+QW-1:0]    c_full;

	assign len_lt = dv_side.len < {1'b0, cfg.rest_length};
	assign a_val  = aprod_b4[PW-1:FRAC_BITS];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			c_full[k] = ((AW+QW)'(phi_b5[k]) << AL) + (AW+QW)'(plo_b5[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			valid_b2 <= 1'b0;
			valid_b3 <= 1'b0;
			valid_b4 <= 1'b0;
			valid_b5 <= 1'b0;
			valid_b6 <= 1'b0;
		end else if (ce) begin
			valid_b1 <= dv_valid;
			valid_b2 <= valid_b1;
			valid_b3 <= valid_b2;
			valid_b4 <= valid_b3;
			valid_b5 <= valid_b4;
			valid_b6 <= valid_b5;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			carry_b1.pass <= dv_side.pass;
			carry_b1.neg  <= dv_side.neg;
			carry_b1.zero <= dv_side.len == '0;
			carry_b1.u    <= dv_quot;
			diff_b1       <= len_lt ? (cfg.rest_length - dv_side.len[W-2:0]) : '0;

			carry_b2 <= carry_b1;
			fprod_b2 <= cfg.stiffness * diff_b1;

			carry_b3 <= carry_b2;
			f_b3     <= (|fprod_b2[PW-1:FRAC_BITS+W-1]) ? '1
				: fprod_b2[FRAC_BITS+W-2:FRAC_BITS];

			carry_b4 <= carry_b3;
			aprod_b4 <= f_b3 * cfg.inverse_mass;

			carry_b5 <= carry_b4;
			for (int k = 0; k < 3; k++) begin
				plo_b5[k] <= a_val[AL-1:0] * carry_b4.u[k];
				phi_b5[k] <= a_val[AW-1:AL] * carry_b4.u[k];
			end

			carry_b6 <= carry_b5;
			for (int k = 0; k < 3; k++) begin
				c_b6[k] <= carry_b5.zero ? '0 : c_full[k][FRAC_BITS+AW-1:FRAC_BITS];
			end
		end
	end

	// signed component, gravity on the vertical axis
	logic signed [2:0][CW-1:0] acc;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [CW-1:0] g;
			logic signed [CW-1:0] c;
			g = (k == 1) ? CW'(cfg.gravity) : '0;
			c = CW'(c_b6[k]);
			acc[k] = carry_b6.neg[k] ? (g - c) : (g + c);
		end
	end

	assign out_push                  = ce && valid_b6;
	assign out_data.dpos_x           = carry_b6.pass.vel_x;
	assign out_data.dpos_y           = carry_b6.pass.vel_y;
	assign out_data.dpos_z           = carry_b6.pass.vel_z;
	assign out_data.accel_x          = sat_out(acc[0]);
	assign out_data.accel_y          = sat_out(acc[1]);
	assign out_data.accel_z          = sat_out(acc[2]);
	assign out_data.touchdown_margin = carry_b6.pass.margin;

endmodule

// ----- rtl/spring_leg_stance_derivative_unit.sv -----
// ----------------------------------------------------------------------------
// spring_leg_stance_derivative_unit: stance phase derivative of a spring leg
// body model with a swing leg touchdown margin.
//
//   channel   handshake            payload                 beat
//   input     push / full          item (item_t fields)    one body state
//   result    empty / pop          result                  one derivative
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data     one register
//
// One item per cycle sustained while the result queue has room. Most of
// the latency from push to empty falling is the bit per stage length root
// and direction divider. Reset leaves all registers at their defaults and
// the queues empty. A full result queue freezes the datapath; the work
// queue and intake register keep taking items until they fill.
// ----------------------------------------------------------------------------
module spring_leg_stance_derivative_unit #(
	parameter int FRAC_BITS = sps_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  sps_pkg::item_t                  item,
	output logic                            empty,
	input  logic                            pop,
	output sps_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sps_pkg::DATA_W-1:0]      cfg_data
);
	import sps_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{inverse_mass: (DATA_W-1)'(1) << FRAC_BITS, default: '0};
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_STIFFNESS: begin
					cfg_q.stiffness <= cfg_data[DATA_W-2:0];
				end
				REG_REST_LENGTH: begin
					cfg_q.rest_length <= cfg_data[DATA_W-2:0];
				end
				REG_INVERSE_MASS: begin
					cfg_q.inverse_mass <= cfg_data[DATA_W-2:0];
				end
				REG_GRAVITY: begin
					cfg_q.gravity <= cfg_data;
				end
				REG_FOOT_X: begin
					cfg_q.foot_x <= cfg_data;
				end
				REG_FOOT_Z: begin
					cfg_q.foot_z <= cfg_data;
				end
				REG_TOUCHDOWN_HEIGHT: begin
					cfg_q.touchdown_height <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	logic       rec_valid;
	logic       mid_full;
	logic       mid_empty;
	logic       mid_pop;
	front_rec_t rec;
	front_rec_t mid_rec;
	logic       out_full;
	logic       out_push;
	result_t    out_data;

	sps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg       (cfg_q),
		.rec_full  (mid_full),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	sps_fifo #(
		.WIDTH ($bits(front_rec_t)),
		.DEPTH (4)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_valid),
		.wdata  (rec),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rec),
		.empty  (mid_empty)
	);

	sps_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (!mid_empty),
		.in_rec   (mid_rec),
		.in_pop   (mid_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_data (out_data)
	);

	sps_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (2)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_data),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
